### hdl/base64_stream_decoder_defines.svh
// ----------------------------------------------------------------------------
// base64_stream_decoder_defines.svh
// Assertion macros shared by the Base64 stream decoder.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_DEFINES_SVH
`define BASE64_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define B64D_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define B64D_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, constants and character mapping for the Base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	// Default depth of the job queue between front and back
	localparam int B64D_QUEUE_DEPTH = 2;

	// Sextet code with bit 6 set marks a character outside the alphabet
	localparam logic [6:0] SEXTET_INVALID = 7'h40;

	// Number of results a single character may cause
	localparam int MAX_RESULTS = 3;

	// One character's worth of results, handed from front to back
	typedef struct packed {
		logic [MAX_RESULTS-1:0][7:0] bytes;   // result k in bytes[k]
		logic [1:0]                  nres;    // results in this job, 1..3
		logic                        byte_ok; // 0 for an end-only marker
		logic                        eom;     // final job of the message
	} job_t;

	// Map an ASCII character to its sextet, or to SEXTET_INVALID
	function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
		logic [6:0] s;
		s = SEXTET_INVALID;
		if (c inside {[8'h41:8'h5A]}) begin
			s = 7'(c - 8'h41);
		end else if (c inside {[8'h61:8'h7A]}) begin
			s = 7'(c - 8'h61 + 8'd26);
		end else if (c inside {[8'h30:8'h39]}) begin
			s = 7'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			s = 7'd62;
		end else if (c == 8'h2F) begin
			s = 7'd63;
		end
		return s;
	endfunction

	// Byte packing of a sextet group
	function automatic logic [7:0] pack_b0(input logic [5:0] a, input logic [5:0] b);
		return {a, b[5:4]};
	endfunction

	function automatic logic [7:0] pack_b1(input logic [5:0] b, input logic [5:0] c);
		return {b[3:0], c[5:2]};
	endfunction

	function automatic logic [7:0] pack_b2(input logic [5:0] c, input logic [5:0] d);
		return {c[1:0], d};
	endfunction

endpackage

### hdl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, classifies them, tracks pending sextets and builds
// one job per character that causes results.
// ----------------------------------------------------------------------------
module b64d_front import b64d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       in_last,
	output logic       push,
	output job_t       job,
	input  logic       q_full
);

	logic [2:0][5:0] pend_q;
	logic [1:0]      cnt_q;
	logic            halted_q;

	logic            acc;
	logic [6:0]      sx;
	logic            is_sx;
	logic            take;
	logic            grp;
	logic [2:0][5:0] pend_u;
	logic [1:0]      cnt_u;

	// Accept whenever the queue has room
	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;

	// Classify the character
	assign sx    = char_to_sextet(in_char);
	assign is_sx = !sx[6];
	assign take  = !halted_q && is_sx;
	assign grp   = take && (cnt_q == 2'd3);

	// Pending set after this character
	always_comb begin
		pend_u = pend_q;
		cnt_u  = cnt_q;
		if (grp) begin
			cnt_u = 2'd0;
		end else if (take) begin
			pend_u[cnt_q] = sx[5:0];
			cnt_u         = cnt_q + 2'd1;
		end
	end

	// Build the job: a full group, and/or the message-end flush
	always_comb begin
		job         = '0;
		job.byte_ok = 1'b1;
		if (grp) begin
			job.bytes[0] = pack_b0(pend_q[0], pend_q[1]);
			job.bytes[1] = pack_b1(pend_q[1], pend_q[2]);
			job.bytes[2] = pack_b2(pend_q[2], sx[5:0]);
			job.nres     = 2'd3;
			job.eom      = in_last;
		end else if (in_last) begin
			job.eom = 1'b1;
			case (cnt_u)
				2'd3: begin
					job.bytes[0] = pack_b0(pend_u[0], pend_u[1]);
					job.bytes[1] = pack_b1(pend_u[1], pend_u[2]);
					job.nres     = 2'd2;
				end
				2'd2: begin
					job.bytes[0] = pack_b0(pend_u[0], pend_u[1]);
					job.nres     = 2'd1;
				end
				default: begin
					job.nres    = 2'd1;
					job.byte_ok = 1'b0;
				end
			endcase
		end
	end

	assign push = acc && (grp || in_last);

	// Control state: count and halt flag, cleared at message end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			halted_q <= 1'b0;
		end else if (acc) begin
			if (in_last) begin
				cnt_q    <= 2'd0;
				halted_q <= 1'b0;
			end else begin
				cnt_q    <= cnt_u;
				halted_q <= halted_q || !is_sx;
			end
		end
	end

	// Sextet payload, only read under the count
	always_ff @(posedge clk) begin
		if (acc) begin
			pend_q <= pend_u;
		end
	end

endmodule

### hdl/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Short job queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module b64d_queue import b64d_pkg::*; #(
	parameter int DEPTH = B64D_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	input  logic pop,
	output job_t rd_job,
	output logic full,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full   = (cnt_q == FULL_CNT);
	assign empty  = (cnt_q == '0);
	assign rd_job = mem_q[rd_ptr_q];

	// Store the pushed job
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### hdl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Walks the head job to the output register, one result per unstalled cycle.
// ----------------------------------------------------------------------------
module b64d_back import b64d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       head,
	input  logic       q_empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic [1:0] out_user
);

	logic [1:0] idx_q;
	logic       load;
	logic       final_beat;
	logic [7:0] sel_byte;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic [1:0] user_q;

	// Load a new result when the output register is free or being drained
	assign load       = !q_empty && (!valid_q || out_ready);
	assign final_beat = (idx_q == head.nres - 2'd1);
	assign pop        = load && final_beat;

	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = head.bytes[0];
			2'd1:    sel_byte = head.bytes[1];
			default: sel_byte = head.bytes[2];
		endcase
	end

	// Result index within the head job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (load) begin
			idx_q <= final_beat ? 2'd0 : idx_q + 2'd1;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Output payload: hold while stalled
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= sel_byte;
			last_q <= final_beat;
			user_q <= {head.eom && final_beat, head.byte_ok};
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;
	assign out_user  = user_q;

endmodule

### hdl/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming Base64 decoder: one character in, up to three bytes out.
// ----------------------------------------------------------------------------
//  channel | dir | tdata         | tlast          | tuser
//  s_*     | in  | in_char[7:0]  | last_char      | -
//  m_*     | out | out_byte[7:0] | last_of_run    | [0] byte_valid, [1] end_of_message
//
//  One character is taken per cycle while the job queue has room.
//  The back drives one result per cycle unless m_tready stalls it; a character
//  causing three results holds the back until all three are out, which the queue absorbs.
//  A character's job is written to the queue at the input transaction; its first
//  result then enters the output register once that register is free.
//  Reset is asynchronous and clears pending count, halt flag, queue and output.
//  A stall on m_tready fills the queue, after which s_tready drops.
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_defines.svh"

module base64_stream_decoder import b64d_pkg::*; #(
	parameter int QUEUE_DEPTH = B64D_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] in_char
	input  logic       s_tlast,  // last_char
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] out_byte
	output logic       m_tlast,  // last_of_run
	output logic [1:0] m_tuser   // [0] byte_valid, [1] end_of_message
);

	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	job_t wr_job;
	job_t rd_job;

	// Front: classify and group
	b64d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_char  (s_tdata),
		.in_last  (s_tlast),
		.push     (q_push),
		.job      (wr_job),
		.q_full   (q_full)
	);

	// Job queue
	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_job (wr_job),
		.pop    (q_pop),
		.rd_job (rd_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	// Back: serialize results
	b64d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (rd_job),
		.q_empty   (q_empty),
		.pop       (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_last  (m_tlast),
		.out_user  (m_tuser)
	);

	// Checks
	`B64D_ASSERT_NOW(a_no_overflow, q_push, !q_full || q_pop, "job pushed into a full queue")
	`B64D_ASSERT_NOW(a_no_underflow, q_pop, !q_empty, "job popped from an empty queue")
	`B64D_ASSERT_NOW(a_eom_is_last, m_tvalid && m_tuser[1], m_tlast, "end of message not on last result of run")
	`B64D_ASSERT_NOW(a_marker_form, m_tvalid && !m_tuser[0], m_tuser[1] && m_tlast && (m_tdata == 8'h00), "end-only marker malformed")

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Base64 stream decoder. A directed table covers
// padding, foreign characters, lone sextets and groups closed on the last
// character; random messages follow, mostly clean alphabet text with some
// padding, foreign bytes and pure noise. Each accepted character runs through
// a bench-side decoder, and every output transaction is compared field by
// field against the oldest expected byte. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int          CYCLE_LIMIT  = 200000;
	localparam int          RANDOM_ITEMS = 284;
	localparam int          LONG_HOLD    = 200;
	localparam int          DRAIN_CYCLES = 20;
	localparam int          HOLD_AT      = 120;
	localparam int          PAUSE_AT     = 220;
	localparam logic [6:0]  NO_SEXTET    = 7'h40;
	localparam logic [7:0]  CH_PAD       = "=";
	localparam logic [7:0]  CH_PLUS      = "+";
	localparam logic [7:0]  CH_SLASH     = "/";

	// One decoded byte as seen on the master side
	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       run_end;
		logic       msg_end;
	} dec_result_t;

	// One character to feed; typed rows carry their own expected bytes
	typedef struct packed {
		logic [7:0]  ch;
		logic        last;
		logic        typed;
		logic [1:0]  nres;
		logic [23:0] bytes;   // result k in bytes[8k +: 8]
		logic        bvalid;
	} char_row_t;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // [7:0] in_char
	logic       s_tlast;   // last_char
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // [7:0] out_byte
	logic       m_tlast;   // last_of_run
	logic [1:0] m_tuser;   // [0] byte_valid, [1] end_of_message

	// Bench-side decoder state
	logic [5:0]  dec_sx [3];
	logic [1:0]  dec_count;
	logic        dec_halted;
	dec_result_t step_res [3];
	int          step_n;

	dec_result_t expected_bytes [$];
	int          mismatches;
	int          results_seen;
	int          items_fed;
	int          burst_left;
	int          cycle_count;
	bit          hold_req;

	char_row_t directed_rows [26] = '{
		// end markers: padding, foreign bytes, lone sextet
		'{CH_PAD,   1'b1, 1'b1, 2'd1, 24'h000000, 1'b0},
		'{8'hFF,    1'b1, 1'b1, 2'd1, 24'h000000, 1'b0},
		'{8'h00,    1'b1, 1'b1, 2'd1, 24'h000000, 1'b0},
		'{"A",      1'b1, 1'b1, 2'd1, 24'h000000, 1'b0},
		// full group of the top sextet, then end on padding
		'{CH_SLASH, 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{CH_SLASH, 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{CH_SLASH, 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{CH_SLASH, 1'b0, 1'b1, 2'd3, 24'hFFFFFF, 1'b1},
		'{CH_PAD,   1'b1, 1'b1, 2'd1, 24'h000000, 1'b0},
		// group closed on the last character
		'{"A",      1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{"A",      1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{"A",      1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{"A",      1'b1, 1'b1, 2'd3, 24'h000000, 1'b1},
		// partial groups of three and two
		'{"T",      1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
		'{"W",      1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
		'{"E",      1'b1, 1'b0, 2'd0, 24'h000000, 1'b0},
		'{"T",      1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
		'{"Q",      1'b1, 1'b0, 2'd0, 24'h000000, 1'b0},
		// alphabet edges, then a high byte halts with two pending
		'{"z",      1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
		'{"0",      1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
		'{"9",      1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
		'{CH_PLUS,  1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
		'{CH_SLASH, 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
		'{"a",      1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
		'{8'h80,    1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
		'{"Q",      1'b1, 1'b0, 2'd0, 24'h000000, 1'b0}
	};

	base64_stream_decoder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// Map a character to its sextet, or to NO_SEXTET
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		if (c >= "A" && c <= "Z") return {1'b0, 6'(c - "A")};
		if (c >= "a" && c <= "z") return {1'b0, 6'(c - "a" + 8'd26)};
		if (c >= "0" && c <= "9") return {1'b0, 6'(c - "0" + 8'd52)};
		if (c == CH_PLUS) return 7'd62;
		if (c == CH_SLASH) return 7'd63;
		return NO_SEXTET;
	endfunction

	// Character of the alphabet for a sextet value
	function automatic logic [7:0] alpha_char(input int unsigned idx);
		if (idx < 26) return 8'("A" + idx);
		if (idx < 52) return 8'("a" + idx - 26);
		if (idx < 62) return 8'("0" + idx - 52);
		return (idx == 62) ? CH_PLUS : CH_SLASH;
	endfunction

	function automatic void add_byte(input logic [7:0] b);
		step_res[step_n] = '{b, 1'b1, 1'b0, 1'b0};
		step_n++;
	endfunction

	// Append one result to the tail of the expected list
	function automatic void queue_expected(input dec_result_t res);
		expected_bytes = {expected_bytes, res};
	endfunction

	// Decode one character into step_res and advance the decoder state
	function automatic void decode_char(input logic [7:0] ch, input logic last);
		logic [6:0] code;
		step_n = 0;
		if (!dec_halted) begin
			code = sextet_of(ch);
			if (code[6]) begin
				dec_halted = 1'b1;
			end else if (dec_count == 2'd3) begin
				add_byte({dec_sx[0], dec_sx[1][5:4]});
				add_byte({dec_sx[1][3:0], dec_sx[2][5:2]});
				add_byte({dec_sx[2][1:0], code[5:0]});
				dec_count = 2'd0;
			end else begin
				dec_sx[dec_count] = code[5:0];
				dec_count++;
			end
		end
		if (last) begin
			if (dec_count >= 2'd2) add_byte({dec_sx[0], dec_sx[1][5:4]});
			if (dec_count == 2'd3) add_byte({dec_sx[1][3:0], dec_sx[2][5:2]});
			if (step_n == 0) begin
				step_res[0] = '{8'h00, 1'b0, 1'b0, 1'b0};
				step_n = 1;
			end
			step_res[step_n-1].msg_end = 1'b1;
			dec_sx     = '{6'd0, 6'd0, 6'd0};
			dec_count  = 2'd0;
			dec_halted = 1'b0;
		end
		if (step_n > 0) step_res[step_n-1].run_end = 1'b1;
	endfunction

	// Idle length before the next character: mostly none, a few long
	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 8) begin
			burst_left = $urandom_range(10, 40);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(input string field, input logic [7:0] want,
			input logic [7:0] got);
		$display("mismatch in %s of result %0d: expected %0h, got %0h",
			field, results_seen, want, got);
		mismatches++;
	endtask

	// Offer one character, wait for its transaction, queue its expected bytes
	task automatic feed_char(input char_row_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= r.ch;
		s_tlast  <= r.last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		decode_char(r.ch, r.last);
		if (r.typed) begin
			for (int k = 0; k < r.nres; k++) begin
				queue_expected('{r.bytes[8*k +: 8], r.bvalid,
					k == r.nres - 1, (k == r.nres - 1) && r.last});
			end
		end else begin
			for (int k = 0; k < step_n; k++) queue_expected(step_res[k]);
		end
		items_fed++;
	endtask

	// Random message: clean text, padded text, text with foreign bytes, noise
	task automatic feed_message();
		int        len;
		int        style;
		int        npad;
		char_row_t row;
		len   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 16);
		style = $urandom_range(0, 9);
		npad  = (style < 7 && $urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
		for (int i = 0; i < len; i++) begin
			row = '{8'h00, i == len - 1, 1'b0, 2'd0, 24'h000000, 1'b0};
			if (i >= len - npad) begin
				row.ch = CH_PAD;
			end else if (style < 7) begin
				row.ch = alpha_char($urandom_range(0, 63));
			end else if (style < 9 && $urandom_range(0, 5) != 0) begin
				row.ch = alpha_char($urandom_range(0, 63));
			end else begin
				row.ch = 8'($urandom_range(0, 255));
			end
			feed_char(row);
		end
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Cycle limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: random ready pattern, plus one long hold-off on request
	initial begin
		int r;
		int len;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 25) begin
					m_tready <= 1'b0;
					len = (r < 3) ? $urandom_range(15, 50) : $urandom_range(1, 3);
				end else begin
					m_tready <= 1'b1;
					len = (r > 90) ? $urandom_range(20, 60) : $urandom_range(1, 8);
				end
				repeat (len - 1) @(posedge clk);
			end
		end
	end

	// Compare each output transaction with the oldest expected byte
	always @(posedge clk) begin
		dec_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch("unexpected result, out_byte", 8'h00, m_tdata);
			end else begin
				want = expected_bytes.pop_front();
				if (m_tdata !== want.data) report_mismatch("out_byte", want.data, m_tdata);
				if (m_tuser[0] !== want.valid)
					report_mismatch("byte_valid", 8'(want.valid), 8'(m_tuser[0]));
				if (m_tlast !== want.run_end)
					report_mismatch("last_of_run", 8'(want.run_end), 8'(m_tlast));
				if (m_tuser[1] !== want.msg_end)
					report_mismatch("end_of_message", 8'(want.msg_end), 8'(m_tuser[1]));
			end
			results_seen++;
		end
	end

	// Reset, directed table, random messages, drain
	initial begin
		bit paused;
		bit held;
		s_tvalid     = 1'b0;
		s_tdata      = 8'h00;
		s_tlast      = 1'b0;
		arst_n       = 1'b0;
		mismatches   = 0;
		results_seen = 0;
		items_fed    = 0;
		burst_left   = 0;
		hold_req     = 1'b0;
		paused       = 1'b0;
		held         = 1'b0;
		dec_sx       = '{6'd0, 6'd0, 6'd0};
		dec_count    = 2'd0;
		dec_halted   = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) feed_char(directed_rows[i]);

		while (items_fed < RANDOM_ITEMS + $size(directed_rows)) begin
			// Stall the receiver for a long stretch while characters keep coming
			if (!held && items_fed >= HOLD_AT) begin
				held       = 1'b1;
				hold_req   = 1'b1;
				burst_left = 80;
			end
			// Hold the sender until every expected byte is out
			if (!paused && items_fed >= PAUSE_AT) begin
				paused = 1'b1;
				s_tvalid <= 1'b0;
				wait (expected_bytes.size() == 0);
				@(posedge clk);
			end
			feed_message();
		end
		s_tvalid <= 1'b0;

		wait (expected_bytes.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
